FILE: hw/rtl/ctks_pkg.sv
// ----------------------------------------------------------------------------
// ctks_pkg
// Shared types and constants for the cosine top-k search block.
// ----------------------------------------------------------------------------
package ctks_pkg;

  localparam int MAX_ENTRIES_DEF  = 256;
  localparam int MAX_DIM_DEF      = 64;
  localparam int MAX_TOP_DEF      = 16;
  localparam int ELEMENT_BITS_DEF = 12;

  localparam int TAG_W      = 16;
  localparam int ELEM_IN_W  = 12;
  localparam int SCORE_W    = 16;
  localparam int RANK_W     = 4;
  localparam int TOP_W      = 5;
  localparam int TOP_RESET  = 16;
  localparam int FRAC_SHIFT = 15;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_MATCH  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LEN,
    ST_MAC,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_SAT,
    ST_RANK,
    ST_EMIT
  } state_t;

endpackage

FILE: hw/rtl/ctks_ram.sv
// ----------------------------------------------------------------------------
// ctks_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/cosine_top_k_search.sv
// ----------------------------------------------------------------------------
// cosine_top_k_search
// Tagged vector table with cosine-similarity top-k queries.
// ----------------------------------------------------------------------------
// Insert and query elements are taken one per cycle; an insert's last beat
// gives its status beat right away. A query's last beat starts a walk over
// all stored entries through one shared multiply-accumulate, square-root and
// divide unit, whose accumulators are W = 2*ELEMENT_BITS + log2(MAX_DIM) + 1
// bits wide (31 by default); with an empty table it gives a single empty
// beat instead. An entry with a zero norm skips the root and divide. The
// match beats then follow one per cycle while the output is not stalled.
// No input beat is taken while a result beat is pending or a query is being
// scored.
// ----------------------------------------------------------------------------
module cosine_top_k_search #(
  parameter int MAX_ENTRIES  = ctks_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_DIM      = ctks_pkg::MAX_DIM_DEF,
  parameter int MAX_TOP      = ctks_pkg::MAX_TOP_DEF,
  parameter int ELEMENT_BITS = ctks_pkg::ELEMENT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] entry_tag, [27:16] element, [31:28] zero
  input  logic [ctks_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] operation
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [17:2] match_tag, [33:18] score, [37:34] rank, [39:38] zero
  output logic [ctks_pkg::OUT_DATA_W-1:0] m_tdata,
  // [1:0] kind
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_wr_en,
  input  logic [ctks_pkg::TOP_W-1:0]      cfg_wr_data
);

  localparam int EB    = ELEMENT_BITS;
  localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int DIMW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LW    = $clog2(MAX_DIM + 1);
  localparam int TW    = $clog2(MAX_TOP + 1);
  localparam int KW    = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
  localparam int ACC_W = 2 * EB + DIMW + 1;
  localparam int DVW   = ACC_W + ctks_pkg::FRAC_SHIFT;
  localparam int SW    = $clog2(DVW + 1);
  localparam int VDEPTH = MAX_ENTRIES * (2 ** DIMW);
  localparam int TAGW  = ctks_pkg::TAG_W;
  localparam int SCW   = ctks_pkg::SCORE_W;

  ctks_pkg::state_t state, state_next;

  logic                      acc;
  logic                      in_op;
  logic [TAGW-1:0]           in_tag;
  logic [EB-1:0]             in_elem;

  logic [ctks_pkg::TOP_W-1:0] top_count;
  logic [CW-1:0]             count;
  logic [LW-1:0]             ilen, qlen, ilen_new, qlen_new;
  logic                      iovf, qovf, iovf_new, qovf_new;
  logic                      ins_room, q_room;

  logic [TW-1:0]             limit;
  logic [1:0]                q_status;
  logic [CW-1:0]             e;
  logic [LW-1:0]             i, n;
  logic                      pend;
  logic [TAGW-1:0]           cur_tag;

  logic signed [ACC_W-1:0]   num;
  logic [ACC_W-1:0]          da, db;
  logic [2*ACC_W-1:0]        prod;
  logic [ACC_W:0]            sq_rem;
  logic [ACC_W-1:0]          root;
  logic [ACC_W:0]            dv_rem;
  logic [DVW-1:0]            dvd, quo;
  logic [SW-1:0]             step;
  logic signed [SCW-1:0]     s;

  logic signed [SCW-1:0]     best_scores [MAX_TOP];
  logic [TAGW-1:0]           best_tags [MAX_TOP];
  logic [TW-1:0]             bcount;
  logic [TW-1:0]             pos;
  logic [TW-1:0]             k;

  logic [1:0]                o_kind, o_status;
  logic [TAGW-1:0]           o_tag;
  logic signed [SCW-1:0]     o_score;
  logic [ctks_pkg::RANK_W-1:0] o_rank;
  logic                      o_last;

  // memories
  logic                      vec_we, tag_we, q_we;
  logic [EB-1:0]             vec_rd, q_rd;
  logic [TAGW-1:0]           tag_rd;
  logic [LW-1:0]             len_rd;

  assign in_op   = s_tuser;
  assign in_tag  = s_tdata[15:0];
  assign in_elem = s_tdata[16 +: EB];
  assign acc     = s_tvalid & s_tready;
  assign s_tready = (state == ctks_pkg::ST_IDLE) && !m_tvalid;

  assign ins_room = ilen < LW'(MAX_DIM);
  assign q_room   = qlen < LW'(MAX_DIM);
  assign ilen_new = ins_room ? ilen + LW'(1) : ilen;
  assign qlen_new = q_room ? qlen + LW'(1) : qlen;
  assign iovf_new = iovf | ~ins_room;
  assign qovf_new = qovf | ~q_room;

  assign vec_we = acc && (in_op == ctks_pkg::OP_INSERT) && ins_room &&
                  (count < CW'(MAX_ENTRIES));
  assign tag_we = acc && (in_op == ctks_pkg::OP_INSERT) && s_tlast &&
                  (count < CW'(MAX_ENTRIES));
  assign q_we   = acc && (in_op == ctks_pkg::OP_QUERY) && q_room;

  ctks_ram #(.WIDTH(EB), .DEPTH(VDEPTH)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr ({count[EW-1:0], ilen[DIMW-1:0]}),
    .wdata (in_elem),
    .raddr ({e[EW-1:0], i[DIMW-1:0]}),
    .rdata (vec_rd)
  );

  ctks_ram #(.WIDTH(TAGW), .DEPTH(MAX_ENTRIES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (count[EW-1:0]),
    .wdata (in_tag),
    .raddr (e[EW-1:0]),
    .rdata (tag_rd)
  );

  ctks_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (count[EW-1:0]),
    .wdata (ilen_new),
    .raddr (e[EW-1:0]),
    .rdata (len_rd)
  );

  ctks_ram #(.WIDTH(EB), .DEPTH(MAX_DIM)) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (qlen[DIMW-1:0]),
    .wdata (in_elem),
    .raddr (i[DIMW-1:0]),
    .rdata (q_rd)
  );

  // shared arithmetic
  logic signed [2*EB-1:0]    p_ab, p_aa, p_bb;
  logic [ACC_W+2:0]          sq_t, sq_trial;
  logic [ACC_W:0]            dv_t;
  logic [ACC_W-1:0]          abs_num;
  logic [DVW-1:0]            sat_pos, sat_neg;

  assign p_ab = $signed(q_rd) * $signed(vec_rd);
  assign p_aa = $signed(q_rd) * $signed(q_rd);
  assign p_bb = $signed(vec_rd) * $signed(vec_rd);

  assign sq_t     = {sq_rem[ACC_W:0], prod[2*ACC_W-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign dv_t     = {dv_rem[ACC_W-1:0], dvd[DVW-1]};
  assign abs_num  = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign sat_pos  = DVW'(32767);
  assign sat_neg  = DVW'(32768);

  // insertion position: entries with score >= s stay ahead
  always_comb begin
    pos = '0;
    for (int j = 0; j < MAX_TOP; j++) begin
      if ((TW'(j) < bcount) && (best_scores[j] >= s)) begin
        pos = pos + TW'(1);
      end
    end
  end

  logic emit_go, emit_last;
  assign emit_go   = !m_tvalid || m_tready;
  assign emit_last = (k + TW'(1)) == bcount;

  always_comb begin
    state_next = state;
    unique case (state)
      ctks_pkg::ST_IDLE: begin
        if (acc && (in_op == ctks_pkg::OP_QUERY) && s_tlast && (count != '0)) begin
          state_next = ctks_pkg::ST_LOAD;
        end
      end
      ctks_pkg::ST_LOAD: state_next = ctks_pkg::ST_LEN;
      ctks_pkg::ST_LEN:  state_next = ctks_pkg::ST_MAC;
      ctks_pkg::ST_MAC: begin
        if ((i >= n) && !pend) begin
          state_next = ctks_pkg::ST_MUL;
        end
      end
      ctks_pkg::ST_MUL: begin
        state_next = ((da == '0) || (db == '0)) ? ctks_pkg::ST_RANK : ctks_pkg::ST_SQRT;
      end
      ctks_pkg::ST_SQRT: begin
        if (step == SW'(ACC_W - 1)) begin
          state_next = ctks_pkg::ST_DIV;
        end
      end
      ctks_pkg::ST_DIV: begin
        if (step == SW'(DVW - 1)) begin
          state_next = ctks_pkg::ST_SAT;
        end
      end
      ctks_pkg::ST_SAT: state_next = ctks_pkg::ST_RANK;
      ctks_pkg::ST_RANK: begin
        state_next = ((e + CW'(1)) == count) ? ctks_pkg::ST_EMIT : ctks_pkg::ST_LOAD;
      end
      ctks_pkg::ST_EMIT: begin
        if (emit_go && emit_last) begin
          state_next = ctks_pkg::ST_IDLE;
        end
      end
      default: state_next = ctks_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctks_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= ctks_pkg::TOP_W'(ctks_pkg::TOP_RESET);
      count     <= '0;
      ilen      <= '0;
      iovf      <= 1'b0;
      qlen      <= '0;
      qovf      <= 1'b0;
      bcount    <= '0;
      m_tvalid  <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        top_count <= cfg_wr_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ctks_pkg::ST_IDLE: begin
          if (acc && (in_op == ctks_pkg::OP_INSERT)) begin
            ilen <= ilen_new;
            iovf <= iovf_new;
            if (s_tlast) begin
              ilen     <= '0;
              iovf     <= 1'b0;
              m_tvalid <= 1'b1;
              if (count < CW'(MAX_ENTRIES)) begin
                count <= count + CW'(1);
              end
            end
          end else if (acc) begin
            qlen <= qlen_new;
            qovf <= qovf_new;
            bcount <= '0;
            if (s_tlast && (count == '0)) begin
              qlen     <= '0;
              qovf     <= 1'b0;
              m_tvalid <= 1'b1;
            end
          end
        end
        ctks_pkg::ST_LEN: pend <= 1'b0;
        ctks_pkg::ST_MAC: pend <= (i < n);
        ctks_pkg::ST_RANK: begin
          if ((pos < limit) && (bcount < limit)) begin
            bcount <= bcount + TW'(1);
          end
        end
        ctks_pkg::ST_EMIT: begin
          if (emit_go) begin
            m_tvalid <= 1'b1;
            if (emit_last) begin
              qlen <= '0;
              qovf <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ctks_pkg::ST_IDLE: begin
        e <= '0;
        k <= '0;
        q_status <= qovf_new ? ctks_pkg::STATUS_TRUNC : ctks_pkg::STATUS_OK;
        if (top_count == '0) begin
          limit <= TW'(1);
        end else if (7'(top_count) > 7'(MAX_TOP)) begin
          limit <= TW'(MAX_TOP);
        end else begin
          limit <= TW'(top_count);
        end
        if (acc && s_tlast) begin
          o_tag   <= '0;
          o_score <= '0;
          o_rank  <= '0;
          o_last  <= 1'b1;
          if (in_op == ctks_pkg::OP_INSERT) begin
            o_kind <= ctks_pkg::KIND_INSERT;
            if (count >= CW'(MAX_ENTRIES)) begin
              o_status <= ctks_pkg::STATUS_FULL;
            end else begin
              o_status <= iovf_new ? ctks_pkg::STATUS_TRUNC : ctks_pkg::STATUS_OK;
            end
          end else begin
            o_kind   <= ctks_pkg::KIND_NONE;
            o_status <= qovf_new ? ctks_pkg::STATUS_TRUNC : ctks_pkg::STATUS_OK;
          end
        end
      end
      ctks_pkg::ST_LEN: begin
        cur_tag <= tag_rd;
        n   <= (qlen < len_rd) ? qlen : len_rd;
        i   <= '0;
        num <= '0;
        da  <= '0;
        db  <= '0;
      end
      ctks_pkg::ST_MAC: begin
        if (i < n) begin
          i <= i + LW'(1);
        end
        if (pend) begin
          num <= num + ACC_W'(p_ab);
          da  <= da + ACC_W'(p_aa);
          db  <= db + ACC_W'(p_bb);
        end
      end
      ctks_pkg::ST_MUL: begin
        prod   <= da * db;
        sq_rem <= '0;
        root   <= '0;
        step   <= '0;
        s      <= '0;
      end
      ctks_pkg::ST_SQRT: begin
        prod <= {prod[2*ACC_W-3:0], 2'b00};
        if (sq_t >= sq_trial) begin
          sq_rem <= (ACC_W+1)'(sq_t - sq_trial);
          root   <= {root[ACC_W-2:0], 1'b1};
        end else begin
          sq_rem <= (ACC_W+1)'(sq_t);
          root   <= {root[ACC_W-2:0], 1'b0};
        end
        if (step == SW'(ACC_W - 1)) begin
          step   <= '0;
          dv_rem <= '0;
          dvd    <= {abs_num, {ctks_pkg::FRAC_SHIFT{1'b0}}};
          quo    <= '0;
        end else begin
          step <= step + SW'(1);
        end
      end
      ctks_pkg::ST_DIV: begin
        step <= step + SW'(1);
        dvd  <= {dvd[DVW-2:0], 1'b0};
        if (dv_t >= {1'b0, root}) begin
          dv_rem <= dv_t - {1'b0, root};
          quo    <= {quo[DVW-2:0], 1'b1};
        end else begin
          dv_rem <= dv_t;
          quo    <= {quo[DVW-2:0], 1'b0};
        end
      end
      ctks_pkg::ST_SAT: begin
        if (num[ACC_W-1]) begin
          s <= (quo > sat_neg) ? SCW'(-32768) : SCW'(-quo);
        end else begin
          s <= (quo > sat_pos) ? SCW'(32767) : SCW'(quo);
        end
      end
      ctks_pkg::ST_RANK: begin
        e <= e + CW'(1);
        if (pos < limit) begin
          for (int j = 0; j < MAX_TOP; j++) begin
            if (TW'(j) == pos) begin
              best_scores[j] <= s;
              best_tags[j]   <= cur_tag;
            end else if ((TW'(j) > pos) && (TW'(j) <= bcount) && (TW'(j) < limit)) begin
              best_scores[j] <= best_scores[(j > 0) ? j - 1 : 0];
              best_tags[j]   <= best_tags[(j > 0) ? j - 1 : 0];
            end
          end
        end
      end
      ctks_pkg::ST_EMIT: begin
        if (emit_go) begin
          o_kind   <= ctks_pkg::KIND_MATCH;
          o_status <= q_status;
          o_tag    <= best_tags[k[KW-1:0]];
          o_score  <= best_scores[k[KW-1:0]];
          o_rank   <= ctks_pkg::RANK_W'(k);
          o_last   <= emit_last;
          k        <= k + TW'(1);
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {2'b00, o_rank, o_score, o_tag, o_status};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

endmodule

FILE: hw/rtl/ctks_checker.sv
// ----------------------------------------------------------------------------
// ctks_checker
// Port-level checks for the cosine top-k search block.
// ----------------------------------------------------------------------------
module ctks_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_no_take_while_pending: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_single_beats: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ctks_pkg::KIND_INSERT || m_tuser == ctks_pkg::KIND_NONE)
    |-> m_tlast) else $error("status or empty beat not last");

  a_plain_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ctks_pkg::KIND_MATCH |-> m_tdata[37:2] == '0)
    else $error("non-match beat carries tag, score or rank");

  a_busy_after_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ctks_pkg::KIND_MATCH && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a match list");

endmodule

bind cosine_top_k_search ctks_checker u_ctks_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
